/* hw/rtl/allag_pkg.sv */
// Shared types, constants and helper functions for the ambient light lux
// and auto-gain block. No dependencies; every other file but allag_stream_if imports this package.
package allag_pkg;

	localparam int CH_W     = 16;
	localparam int LUX_W    = 32;
	localparam int IAC_W    = 28;
	localparam int MUL_A_W  = 40;
	localparam int MUL_B_W  = 12;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
	localparam int DIV_N_W  = MUL_P_W;
	localparam int DIV_D_W  = 29;
	localparam int APB_AW   = 5;
	localparam int APB_DW   = 32;

	localparam logic [7:0]  ATIME_RST  = 8'd219;
	localparam logic [11:0] GLASS_RST  = 12'd49;
	localparam logic [11:0] MIX_B_RST  = 12'd186;
	localparam logic [11:0] MIX_C_RST  = 12'd74;
	localparam logic [11:0] MIX_D_RST  = 12'd129;
	localparam logic [11:0] DEV_RST    = 12'd52;
	localparam logic [4:0]  GCC_RST    = 5'd1;
	localparam logic [1:0]  GAIN_RST   = 2'd2;

	localparam logic REQ_READ = 1'b0;
	localparam logic REQ_INT  = 1'b1;

	typedef enum logic [2:0] {
		REG_ATIME  = 3'd0,
		REG_GLASS  = 3'd1,
		REG_MIX_B  = 3'd2,
		REG_MIX_C  = 3'd3,
		REG_MIX_D  = 3'd4,
		REG_DEV    = 3'd5,
		REG_GCC    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic            req_type;
		logic [CH_W-1:0] ch0;
		logic [CH_W-1:0] ch1;
		logic            als_int;
	} sample_t;

	typedef struct packed {
		logic [LUX_W-1:0] lux;
		logic [1:0]       gain_index;
		logic             low_gain_mode;
		logic [CH_W-1:0]  thresh_low;
		logic [CH_W-1:0]  thresh_high;
		logic             event_raised;
	} result_t;

	typedef struct packed {
		logic [7:0]  atime;
		logic [11:0] glass_attenuation;
		logic [11:0] mix_b;
		logic [11:0] mix_c;
		logic [11:0] mix_d;
		logic [11:0] device_factor;
		logic [4:0]  gain_change_count;
	} cfg_t;

	// Gain multiplier times 10000 for the 1x, 8x, 16x and 120x settings.
	function automatic logic [20:0] gain_den(input logic [1:0] g);
		logic [20:0] v;
		unique case (g)
			2'd0: v = 21'd10000;
			2'd1: v = 21'd80000;
			2'd2: v = 21'd160000;
			2'd3: v = 21'd1200000;
			default: v = 21'd10000;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] calc_alsit(input logic [7:0] atime);
		logic [8:0]  span;
		logic [21:0] pr;
		span = 9'd256 - {1'b0, atime};
		pr   = 22'(span) * 22'd5591;
		return (pr[21:11] > 11'd255) ? 8'hFF : pr[18:11];
	endfunction

	function automatic logic [CH_W-1:0] calc_ch0_max(input logic [7:0] atime);
		logic [8:0] span;
		span = 9'd256 - {1'b0, atime};
		return (span >= 9'd64) ? 16'hFFFF : {span[5:0] - 6'd1, 10'h3FF};
	endfunction

	// Exact floor(x / 5) for x below 2**19 by reciprocal multiplication.
	function automatic logic [16:0] div5(input logic [18:0] x);
		logic [38:0] pr;
		pr = 39'(x) * 39'd838861;
		return pr[38:22];
	endfunction

endpackage

/* hw/rtl/allag_stream_if.sv */
// Valid/ready channel carrying one item per transfer.
// The payload type comes from allag_pkg at the point of instantiation.
interface allag_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/allag_regs.sv */
// APB configuration register file with reset values and read-back.
// Depends on allag_pkg for the register map and the configuration struct.
module allag_regs import allag_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	reg_idx_t idx;
	cfg_t     cfg_q;

	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.atime             <= ATIME_RST;
			cfg_q.glass_attenuation <= GLASS_RST;
			cfg_q.mix_b             <= MIX_B_RST;
			cfg_q.mix_c             <= MIX_C_RST;
			cfg_q.mix_d             <= MIX_D_RST;
			cfg_q.device_factor     <= DEV_RST;
			cfg_q.gain_change_count <= GCC_RST;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_ATIME: cfg_q.atime             <= pwdata[7:0];
				REG_GLASS: cfg_q.glass_attenuation <= pwdata[11:0];
				REG_MIX_B: cfg_q.mix_b             <= pwdata[11:0];
				REG_MIX_C: cfg_q.mix_c             <= pwdata[11:0];
				REG_MIX_D: cfg_q.mix_d             <= pwdata[11:0];
				REG_DEV:   cfg_q.device_factor     <= pwdata[11:0];
				REG_GCC:   cfg_q.gain_change_count <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ATIME: prdata = APB_DW'(cfg_q.atime);
			REG_GLASS: prdata = APB_DW'(cfg_q.glass_attenuation);
			REG_MIX_B: prdata = APB_DW'(cfg_q.mix_b);
			REG_MIX_C: prdata = APB_DW'(cfg_q.mix_c);
			REG_MIX_D: prdata = APB_DW'(cfg_q.mix_d);
			REG_DEV:   prdata = APB_DW'(cfg_q.device_factor);
			REG_GCC:   prdata = APB_DW'(cfg_q.gain_change_count);
			default:   prdata = '0;
		endcase
	end

endmodule

/* hw/rtl/allag_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on allag_pkg for operand and product widths.
module allag_mul import allag_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic               done,
	output logic [MUL_P_W-1:0] p
);

	localparam int CNT_W = $clog2(MUL_B_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [MUL_P_W-1:0] acc_q;
	logic [MUL_P_W-1:0] a_q;
	logic [MUL_B_W-1:0] b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				acc_q  <= '0;
				a_q    <= MUL_P_W'(a);
				b_q    <= b;
			end else if (busy_q) begin
				if (b_q[0]) begin
					acc_q <= acc_q + a_q;
				end
				a_q   <= a_q << 1;
				b_q   <= b_q >> 1;
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(MUL_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

/* hw/rtl/allag_div.sv */
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on allag_pkg for dividend and divisor widths.
module allag_div import allag_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] num,
	input  logic [DIV_D_W-1:0] den,
	output logic               done,
	output logic [DIV_N_W-1:0] quo
);

	localparam int CNT_W = $clog2(DIV_N_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIV_N_W-1:0] quo_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] den_q;
	logic [DIV_D_W:0]   rem_sh;
	logic [DIV_D_W+1:0] diff;

	assign rem_sh = {rem_q, quo_q[DIV_N_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				quo_q  <= num;
				rem_q  <= '0;
				den_q  <= den;
			end else if (busy_q) begin
				if (!diff[DIV_D_W+1]) begin
					rem_q <= diff[DIV_D_W-1:0];
					quo_q <= {quo_q[DIV_N_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[DIV_D_W-1:0];
					quo_q <= {quo_q[DIV_N_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* hw/rtl/ambient_light_lux_autogain.sv */
// Top level: lux computation and automatic gain control for a two-channel light sensor.
// Depends on allag_pkg, allag_stream_if, allag_regs, allag_mul and allag_div.
//
//   Channel  Kind         Payload    Transfer when
//   sample   valid/ready  sample_t   sample.valid && sample.ready
//   result   valid/ready  result_t   result.valid && result.ready
//   apb      APB write    32 bits    psel && penable && pwrite
//
// A read item runs five serial multiplications and a serial division, then
// loads the result register; the next item is taken back in the idle state.
// An interrupt item computes its thresholds and then loads the result register.
// One item is in work at a time; the result register lets the next item
// transfer while the previous result waits. Reset clears the control, gain and threshold state.
module ambient_light_lux_autogain import allag_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	allag_stream_if.sink      sample,
	allag_stream_if.source    result
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MIX_B,
		ST_MIX_C,
		ST_MIX_D,
		ST_GLASS,
		ST_DEV,
		ST_DIV,
		ST_THRESH,
		ST_DONE
	} state_t;

	cfg_t               cfg;
	state_t             state_q;
	sample_t            item_q;
	logic [DIV_D_W-1:0] den_q;
	logic [IAC_W-1:0]   pb_q;
	logic [IAC_W-1:0]   pc_q;
	logic [DIV_N_W-1:0] quo_q;
	logic [DIV_N_W-1:0] div_num_q;
	logic [CH_W-1:0]    tlo_q;
	logic               mul_start_q;
	logic [MUL_A_W-1:0] mul_a_q;
	logic [MUL_B_W-1:0] mul_b_q;
	logic               div_start_q;
	logic [1:0]         gain_q;
	logic               low_gain_q;
	logic [3:0]         cnt_q;
	logic [CH_W-1:0]    thr_lo_q;
	logic [CH_W-1:0]    thr_hi_q;
	result_t            res_q;
	logic               res_valid_q;

	logic               mul_done;
	logic [MUL_P_W-1:0] mul_p;
	logic               div_done;
	logic [DIV_N_W-1:0] div_q;

	logic [22:0]        ch0x100;
	logic signed [29:0] m1;
	logic signed [29:0] m2;
	logic signed [29:0] best;
	logic [IAC_W-1:0]   iac;
	logic [CH_W-1:0]    cmax;
	logic [23:0]        a90;
	logic [23:0]        b100;
	logic               too_high;
	logic               too_low;
	logic [4:0]         lim;
	logic [1:0]         gain_n;
	logic               low_gain_n;
	logic [3:0]         cnt_n;
	logic [54:0]        q6;
	logic [54:0]        scaled;
	logic [LUX_W-1:0]   lux_sat;
	logic [16:0]        hi17;
	logic [CH_W-1:0]    thr_hi_n;

	allag_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	allag_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	allag_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_q)
	);

	// The larger of the two channel mixes, clamped at zero.
	assign ch0x100 = 23'(item_q.ch0) * 23'd100;
	assign m1      = $signed({7'd0, ch0x100}) - $signed({2'd0, pb_q});
	assign m2      = $signed({2'd0, pc_q}) - $signed({2'd0, mul_p[IAC_W-1:0]});
	assign best    = (m1 > m2) ? m1 : m2;
	assign iac     = best[29] ? '0 : best[IAC_W-1:0];

	// Range tests against floor(cmax*90/100) and floor(cmax*10/100), rewritten
	// to avoid the division.
	assign cmax     = calc_ch0_max(cfg.atime);
	assign a90      = 24'(cmax) * 24'd90;
	assign b100     = (24'(item_q.ch0) + 24'd1) * 24'd100;
	assign too_high = a90 < b100;
	assign too_low  = (24'(item_q.ch0) * 24'd100) <= (24'(cmax) * 24'd10);

	always_comb begin
		if (cfg.gain_change_count == 5'd0) begin
			lim = 5'd1;
		end else if (cfg.gain_change_count > 5'd16) begin
			lim = 5'd16;
		end else begin
			lim = cfg.gain_change_count;
		end
	end

	always_comb begin
		gain_n     = gain_q;
		low_gain_n = low_gain_q;
		cnt_n      = cnt_q;
		if (too_high || too_low) begin
			if (({1'b0, cnt_q} + 5'd1) < lim) begin
				cnt_n = cnt_q + 4'd1;
			end else begin
				cnt_n = '0;
				if (too_high) begin
					if (gain_q == 2'd0 && !low_gain_q) begin
						low_gain_n = 1'b1;
					end else if (gain_q != 2'd0) begin
						gain_n = gain_q - 2'd1;
					end
				end else begin
					if (low_gain_q) begin
						low_gain_n = 1'b0;
					end else if (gain_q != 2'd3) begin
						gain_n = gain_q + 2'd1;
					end
				end
			end
		end
	end

	assign q6      = ({3'd0, quo_q} << 2) + ({3'd0, quo_q} << 1);
	assign scaled  = low_gain_q ? q6 : {3'd0, quo_q};
	assign lux_sat = (|scaled[54:LUX_W]) ? '1 : scaled[LUX_W-1:0];

	assign hi17     = div5(19'(item_q.ch0) * 19'd6);
	assign thr_hi_n = (hi17 > {1'b0, cmax}) ? cmax : hi17[CH_W-1:0];

	assign sample.ready = (state_q == ST_IDLE);
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			res_valid_q <= 1'b0;
			gain_q      <= GAIN_RST;
			low_gain_q  <= 1'b0;
			cnt_q       <= '0;
			thr_lo_q    <= '1;
			thr_hi_q    <= '0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (state_q == ST_DONE && (!res_valid_q || result.ready)) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						item_q <= sample.data;
						den_q  <= DIV_D_W'(calc_alsit(cfg.atime)) * DIV_D_W'(gain_den(gain_q));
						if (sample.data.req_type == REQ_READ) begin
							mul_a_q     <= MUL_A_W'(sample.data.ch1);
							mul_b_q     <= cfg.mix_b;
							mul_start_q <= 1'b1;
							state_q     <= ST_MIX_B;
						end else begin
							state_q <= ST_THRESH;
						end
					end
				end
				ST_MIX_B: begin
					if (mul_done) begin
						pb_q        <= mul_p[IAC_W-1:0];
						mul_a_q     <= MUL_A_W'(item_q.ch0);
						mul_b_q     <= cfg.mix_c;
						mul_start_q <= 1'b1;
						state_q     <= ST_MIX_C;
					end
				end
				ST_MIX_C: begin
					if (mul_done) begin
						pc_q        <= mul_p[IAC_W-1:0];
						mul_a_q     <= MUL_A_W'(item_q.ch1);
						mul_b_q     <= cfg.mix_d;
						mul_start_q <= 1'b1;
						state_q     <= ST_MIX_D;
					end
				end
				ST_MIX_D: begin
					if (mul_done) begin
						mul_a_q     <= MUL_A_W'(iac);
						mul_b_q     <= cfg.glass_attenuation;
						mul_start_q <= 1'b1;
						state_q     <= ST_GLASS;
					end
				end
				ST_GLASS: begin
					if (mul_done) begin
						mul_a_q     <= mul_p[MUL_A_W-1:0];
						mul_b_q     <= cfg.device_factor;
						mul_start_q <= 1'b1;
						state_q     <= ST_DEV;
					end
				end
				ST_DEV: begin
					if (mul_done) begin
						div_num_q   <= mul_p;
						div_start_q <= 1'b1;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						quo_q   <= div_q;
						state_q <= ST_DONE;
					end
				end
				ST_THRESH: begin
					tlo_q   <= CH_W'(div5({1'b0, item_q.ch0, 2'b00}));
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_valid_q || result.ready) begin
						gain_q              <= gain_n;
						low_gain_q          <= low_gain_n;
						cnt_q               <= cnt_n;
						res_q.lux           <= (item_q.req_type == REQ_READ) ? lux_sat : '0;
						res_q.gain_index    <= gain_n;
						res_q.low_gain_mode <= low_gain_n;
						if (item_q.req_type == REQ_INT && item_q.als_int) begin
							thr_lo_q           <= tlo_q;
							thr_hi_q           <= thr_hi_n;
							res_q.thresh_low   <= tlo_q;
							res_q.thresh_high  <= thr_hi_n;
							res_q.event_raised <= 1'b1;
						end else begin
							res_q.thresh_low   <= thr_lo_q;
							res_q.thresh_high  <= thr_hi_q;
							res_q.event_raised <= 1'b0;
						end
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_gain_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(gain_q) |-> (gain_q == $past(gain_q) + 2'd1 || gain_q == $past(gain_q) - 2'd1))
		else $error("gain index moved by more than one step");

	a_low_gain_at_min: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(low_gain_q) |-> (gain_q == 2'd0))
		else $error("low-gain mode entered above the lowest gain");

	a_event_no_lux: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.event_raised) |-> (res_q.lux == '0))
		else $error("interrupt result carries a lux value");

	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MIX_B || state_q == ST_MIX_C || state_q == ST_MIX_D ||
			state_q == ST_GLASS || state_q == ST_DEV))
		else $error("multiplier finished outside a multiply step");

endmodule
